### rtl/kem_pkg.sv
// Shared types and constants of the key event to MIDI message translator.
package kem_pkg;

   // Field widths of the request and response items
   localparam int OP_W     = 3;
   localparam int KEY_W    = 5;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int BEND_W   = 14;
   localparam int OCT_W    = 5;
   localparam int CHAN_W   = 4;
   localparam int KIND_W   = 3;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   // Fixed musical constants
   localparam logic signed [9:0]  NOTES_PER_OCTAVE = 10'sd12;
   localparam logic signed [9:0]  NOTE_MAX         = 10'sd127;
   localparam logic signed [15:0] BEND_MIN         = -16'sd8192;
   localparam logic signed [15:0] BEND_MAX         = 16'sd8191;

   // Reset values of the configuration registers
   localparam logic signed [OCT_W-1:0] MIN_OCTAVE_RST   = -5'sd1;
   localparam logic signed [OCT_W-1:0] MAX_OCTAVE_RST   = 5'sd9;
   localparam logic signed [OCT_W-1:0] START_OCTAVE_RST = 5'sd4;
   localparam logic [VEL_W-1:0]        VELOCITY_RST     = 7'd127;
   localparam logic [CHAN_W-1:0]       CHANNEL_RST      = 4'd0;
   localparam logic [BEND_W-1:0]       BEND_STEP_RST    = 14'd82;

   typedef enum logic [OP_W-1:0] {
      OP_KEY       = 3'd0,
      OP_SUSTAIN   = 3'd1,
      OP_MOD       = 3'd2,
      OP_BEND_UP   = 3'd3,
      OP_BEND_DOWN = 3'd4,
      OP_OCT_DOWN  = 3'd5,
      OP_OCT_UP    = 3'd6,
      OP_TICK      = 3'd7
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      MSG_NOTE_ON  = 3'd0,
      MSG_NOTE_OFF = 3'd1,
      MSG_SUSTAIN  = 3'd2,
      MSG_MOD      = 3'd3,
      MSG_BEND     = 3'd4,
      MSG_OCTAVE   = 3'd5
   } msg_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_OCTAVE   = 3'd0,
      CSR_MAX_OCTAVE   = 3'd1,
      CSR_START_OCTAVE = 3'd2,
      CSR_VELOCITY     = 3'd3,
      CSR_CHANNEL      = 3'd4,
      CSR_BEND_STEP    = 3'd5
   } csr_index_type;

   // Bend direction: two's complement of -1, 0, +1
   typedef enum logic [1:0] {
      DIR_NONE = 2'b00,
      DIR_UP   = 2'b01,
      DIR_DOWN = 2'b11
   } bend_dir_type;

   typedef struct packed {
      logic signed [OCT_W-1:0] min_octave;
      logic signed [OCT_W-1:0] max_octave;
      logic signed [OCT_W-1:0] start_octave;
      logic [VEL_W-1:0]        velocity;
      logic [CHAN_W-1:0]       channel;
      logic [BEND_W-1:0]       bend_step;
      logic                    load_octave;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key_num;
      logic             pressed;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]        msg_kind;
      logic [NOTE_W-1:0]        note;
      logic [VEL_W-1:0]         velocity;
      logic                     switch_on;
      logic signed [BEND_W-1:0] bend_value;
      logic signed [OCT_W-1:0]  octave_now;
      logic [CHAN_W-1:0]        channel;
   } rsp_item_type;

endpackage

### rtl/kem_csr.sv
// Configuration registers of the key event translator.
module kem_csr
   import kem_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in             = cfg_ff;
      cfg_in.load_octave = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_OCTAVE:   cfg_in.min_octave = csr_data[OCT_W-1:0];
            CSR_MAX_OCTAVE:   cfg_in.max_octave = csr_data[OCT_W-1:0];
            CSR_START_OCTAVE: begin
               cfg_in.start_octave = csr_data[OCT_W-1:0];
               cfg_in.load_octave  = 1'b1;
            end
            CSR_VELOCITY:     cfg_in.velocity  = csr_data[VEL_W-1:0];
            CSR_CHANNEL:      cfg_in.channel   = csr_data[CHAN_W-1:0];
            CSR_BEND_STEP:    cfg_in.bend_step = csr_data[BEND_W-1:0];
            default:          ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_octave   <= MIN_OCTAVE_RST;
         cfg_ff.max_octave   <= MAX_OCTAVE_RST;
         cfg_ff.start_octave <= START_OCTAVE_RST;
         cfg_ff.velocity     <= VELOCITY_RST;
         cfg_ff.channel      <= CHANNEL_RST;
         cfg_ff.bend_step    <= BEND_STEP_RST;
         cfg_ff.load_octave  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/kem_note_mem.sv
// Held-note memory: one registered read port, one write port, same-entry forwarding.
module kem_note_mem
   import kem_pkg::*;
#(
   parameter int NUM_KEYS = 25,
   parameter int ADDR_W   = 5
)
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [NOTE_W-1:0] wr_data,
   output logic [NOTE_W-1:0] rd_data
);

   logic [NOTE_W-1:0] mem [NUM_KEYS];
   logic [NOTE_W-1:0] rd_q_ff;
   logic              fwd_ff;
   logic              fwd_in;
   logic [NOTE_W-1:0] fwd_data_ff;

   // A read that meets a write to the same entry takes the new note.
   assign fwd_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

### rtl/kem_engine.sv
// Message engine: octave, bend and held-key state, and message formation.
module kem_engine
   import kem_pkg::*;
#(
   parameter int NUM_KEYS = 25,
   parameter int ADDR_W   = 5
)
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  req_item_type      item,
   input  logic              key_in_range,
   input  logic [ADDR_W-1:0] key_addr,
   input  logic [NOTE_W-1:0] held_note,
   input  logic              commit,
   output logic              has_result,
   output rsp_item_type      result,
   output logic              note_wr_en,
   output logic [NOTE_W-1:0] note_wr_data
);

   logic signed [OCT_W-1:0]  octave_ff, octave_in;
   logic signed [BEND_W-1:0] bend_ff, bend_in;
   bend_dir_type             dir_ff, dir_in;
   logic [NUM_KEYS-1:0]      held_valid_ff, held_valid_in;

   logic signed [9:0]        oct_ext;
   logic signed [9:0]        note_sum;
   logic [NOTE_W-1:0]        note_sat;
   logic signed [OCT_W:0]    oct_step;
   logic signed [OCT_W:0]    oct_clamp;
   logic signed [15:0]       bend_sum;
   logic signed [15:0]       bend_sat;

   assign oct_ext  = {{(10-OCT_W){octave_ff[OCT_W-1]}}, octave_ff};
   assign note_sum = (oct_ext + 10'sd1) * NOTES_PER_OCTAVE
                     + $signed({{(10-KEY_W){1'b0}}, item.key_num});

   always_comb begin
      if (note_sum < 10'sd0) begin
         note_sat = '0;
      end else if (note_sum > NOTE_MAX) begin
         note_sat = NOTE_MAX[NOTE_W-1:0];
      end else begin
         note_sat = note_sum[NOTE_W-1:0];
      end
   end

   // Clamp to the upper limit first, then to the lower one.
   always_comb begin
      oct_step  = {octave_ff[OCT_W-1], octave_ff}
                  + ((item.op == OP_OCT_UP) ? 6'sd1 : -6'sd1);
      oct_clamp = oct_step;
      if (oct_clamp > $signed({cfg.max_octave[OCT_W-1], cfg.max_octave})) begin
         oct_clamp = {cfg.max_octave[OCT_W-1], cfg.max_octave};
      end
      if (oct_clamp < $signed({cfg.min_octave[OCT_W-1], cfg.min_octave})) begin
         oct_clamp = {cfg.min_octave[OCT_W-1], cfg.min_octave};
      end
   end

   always_comb begin
      if (dir_ff == DIR_DOWN) begin
         bend_sum = {{2{bend_ff[BEND_W-1]}}, bend_ff} - $signed({2'b00, cfg.bend_step});
      end else begin
         bend_sum = {{2{bend_ff[BEND_W-1]}}, bend_ff} + $signed({2'b00, cfg.bend_step});
      end
      if (bend_sum < BEND_MIN) begin
         bend_sat = BEND_MIN;
      end else if (bend_sum > BEND_MAX) begin
         bend_sat = BEND_MAX;
      end else begin
         bend_sat = bend_sum;
      end
   end

   always_comb begin
      octave_in      = octave_ff;
      bend_in        = bend_ff;
      dir_in         = dir_ff;
      held_valid_in  = held_valid_ff;
      has_result     = 1'b0;
      note_wr_en     = 1'b0;
      note_wr_data   = note_sat;
      result         = '0;
      result.channel = cfg.channel;
      unique case (item.op)
         OP_KEY: begin
            if (key_in_range) begin
               if (item.pressed) begin
                  has_result              = 1'b1;
                  result.msg_kind         = MSG_NOTE_ON;
                  result.note             = note_sat;
                  result.velocity         = cfg.velocity;
                  note_wr_en              = 1'b1;
                  held_valid_in[key_addr] = 1'b1;
               end else if (held_valid_ff[key_addr]) begin
                  has_result              = 1'b1;
                  result.msg_kind         = MSG_NOTE_OFF;
                  result.note             = held_note;
                  held_valid_in[key_addr] = 1'b0;
               end
            end
         end
         OP_SUSTAIN, OP_MOD: begin
            has_result       = 1'b1;
            result.msg_kind  = (item.op == OP_SUSTAIN) ? MSG_SUSTAIN : MSG_MOD;
            result.switch_on = item.pressed;
         end
         OP_BEND_UP, OP_BEND_DOWN: begin
            if (item.pressed) begin
               dir_in = (item.op == OP_BEND_UP) ? DIR_UP : DIR_DOWN;
            end else begin
               dir_in  = DIR_NONE;
               bend_in = '0;
            end
            has_result        = 1'b1;
            result.msg_kind   = MSG_BEND;
            result.bend_value = bend_in;
         end
         OP_OCT_DOWN, OP_OCT_UP: begin
            if (item.pressed && (oct_clamp[OCT_W-1:0] != octave_ff)) begin
               octave_in         = oct_clamp[OCT_W-1:0];
               has_result        = 1'b1;
               result.msg_kind   = MSG_OCTAVE;
               result.octave_now = octave_in;
            end
         end
         OP_TICK: begin
            if ((dir_ff != DIR_NONE) && (bend_sat[BEND_W-1:0] != bend_ff)) begin
               bend_in           = bend_sat[BEND_W-1:0];
               has_result        = 1'b1;
               result.msg_kind   = MSG_BEND;
               result.bend_value = bend_in;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff     <= START_OCTAVE_RST;
         bend_ff       <= '0;
         dir_ff        <= DIR_NONE;
         held_valid_ff <= '0;
      end else if (cfg.load_octave) begin
         octave_ff <= cfg.start_octave;
      end else if (commit) begin
         octave_ff     <= octave_in;
         bend_ff       <= bend_in;
         dir_ff        <= dir_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

### rtl/key_events_to_midi_messages_top.sv
// Top level of the key event to MIDI message translator.
//
// Usage:
//  - req channel: one request per key switch event or timer tick. req_tuser carries
//    the op code, req_tdata the key number and the pressed flag.
//  - rsp channel: zero or one MIDI message descriptor per request, in request
//    order. rsp_tuser carries the message kind, rsp_tdata the message fields.
//  - csr channel: register writes (index 0..5), always ready; write only while idle.
//    Writing the start octave also loads the current octave.
// Path: an accepted request is registered in the execute stage, then its message in
//  the output register that drives rsp, where it can be taken.
// Throughput: one request per cycle unless the output stalls; set by the held-note
//  memory read-modify-write (read at accept, write at execute, same-key hits forwarded).
// Reset: synchronous; clears the pipeline, all held keys, the bend state and
//  restores every register default, octave back to 4.
// Stall: the output register holds a message until rsp_tready; the stage behind it
//  keeps accepting while it is empty, then holds req_tready low.
module key_events_to_midi_messages_top
   import kem_pkg::*;
#(
   parameter int NUM_KEYS = 25
)
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: key_num[4:0], pressed[5], zero fill [7:6]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: op[2:0]
   input  logic [OP_W-1:0]       req_tuser,
   // rsp_tdata: note[6:0], velocity[13:7], switch_on[14], bend_value[28:15],
   //            octave_now[33:29], channel[37:34], zero fill [39:38]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: msg_kind[2:0]
   output logic [KIND_W-1:0]     rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   cfg_type           cfg;
   req_item_type      req_item;
   logic              req_fire;
   logic              req_in_range;
   logic [ADDR_W-1:0] req_addr;

   // Execute stage: request whose held note is being read
   logic              s1_valid_ff, s1_valid_in;
   req_item_type      s1_item_ff;
   logic              s1_in_range_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_go;

   // Output register
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_item_ff;
   logic              out_free;

   logic              has_result;
   rsp_item_type      result;
   logic              note_wr_en;
   logic [NOTE_W-1:0] note_wr_data;
   logic [NOTE_W-1:0] held_note;

   assign csr_ready = 1'b1;

   assign req_item.op      = req_tuser;
   assign req_item.key_num = req_tdata[KEY_W-1:0];
   assign req_item.pressed = req_tdata[KEY_W];

   assign req_in_range = (int'(req_item.key_num) < NUM_KEYS);
   assign req_addr     = ADDR_W'(req_item.key_num);

   // Advance the execute stage when its message has a place to go, or it has none.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (out_free || !has_result);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_go && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff     <= req_item;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
      end
      if (s1_go && has_result) begin
         out_item_ff <= result;
      end
   end

   kem_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kem_note_mem #(
      .NUM_KEYS (NUM_KEYS),
      .ADDR_W   (ADDR_W)
   ) u_note_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .wr_en   (s1_go && note_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (note_wr_data),
      .rd_data (held_note)
   );

   kem_engine #(
      .NUM_KEYS (NUM_KEYS),
      .ADDR_W   (ADDR_W)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .item         (s1_item_ff),
      .key_in_range (s1_in_range_ff),
      .key_addr     (s1_addr_ff),
      .held_note    (held_note),
      .commit       (s1_go),
      .has_result   (has_result),
      .result       (result),
      .note_wr_en   (note_wr_en),
      .note_wr_data (note_wr_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.msg_kind;
   assign rsp_tdata  = {2'b00,
                        out_item_ff.channel,
                        out_item_ff.octave_now,
                        out_item_ff.bend_value,
                        out_item_ff.switch_on,
                        out_item_ff.velocity,
                        out_item_ff.note};

endmodule

### rtl/kem_checker.sv
// Port-level checker of the key event translator, bound to the top level.
module kem_checker
   import kem_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0]     rsp_tuser
);

   // Hold a stalled message.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Drop any pending message on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Emit only defined message kinds.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= MSG_OCTAVE))
      else $error("undefined message kind");

   // Note-off carries a zero velocity and no bend or octave fields.
   a_note_off_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == MSG_NOTE_OFF) |->
         (rsp_tdata[13:7] == 7'd0) && (rsp_tdata[33:14] == 20'd0))
      else $error("note-off with stray fields");

endmodule

bind key_events_to_midi_messages_top kem_checker u_kem_checker (.*);
